>>> hw/rtl/rchp_pkg.sv
// shared types and constants for the ray pick against a convex solid
package rchp_pkg;

   // input word: plane load or ray query
   typedef struct packed {
      logic               operation;
      logic [2:0]         plane_index;
      logic signed [31:0] coef_a;
      logic signed [31:0] coef_b;
      logic signed [31:0] coef_c;
      logic signed [31:0] coef_d;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
   } req_type;

   // result word of one query
   typedef struct packed {
      logic               hit;
      logic signed [31:0] hit_x;
      logic signed [31:0] hit_y;
      logic signed [31:0] hit_z;
      logic [30:0]        ray_param;
      logic [31:0]        distance;
   } rsp_type;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam int PLANE_SEL_W = 4;
   localparam int DIV_STEPS   = 31;
   localparam int SQRT_STEPS  = 32;
   localparam int STEP_W      = 5;
   localparam int MUL_W       = 34;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int SUM_W       = 67;

   // datapath operations
   typedef enum logic [4:0] {
      DP_NONE,
      DP_LOAD,
      DP_CAPTURE,
      DP_VAL_INIT,
      DP_MUL_ORIGIN,
      DP_MUL_DIR,
      DP_MUL_T,
      DP_MUL_POINT,
      DP_MUL_SQ,
      DP_ACC,
      DP_SAVE_VAL,
      DP_SAVE_DOT,
      DP_DIV_INIT,
      DP_DIV_STEP,
      DP_PT_SET,
      DP_IN_INIT,
      DP_UPDATE,
      DP_SQ_INIT,
      DP_SQ_ACC,
      DP_SQRT_INIT,
      DP_SQRT_STEP,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type              op;
      logic [PLANE_SEL_W-1:0] plane;
      logic [1:0]             term;
   } dp_cmd_type;

   typedef struct packed {
      logic cand;
      logic tol_fail;
   } dp_status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_PLANE,
      S_VMUL,
      S_VACC,
      S_VSAVE,
      S_DMUL,
      S_DACC,
      S_DSAVE,
      S_CHECK,
      S_DIV,
      S_PMUL,
      S_PSET,
      S_IINIT,
      S_IMUL,
      S_IACC,
      S_ICHK,
      S_UPDATE,
      S_SQINIT,
      S_SQMUL,
      S_SQACC,
      S_SQRTI,
      S_SQRT,
      S_DONE
   } state_type;

endpackage

>>> hw/rtl/ray_convex_hexahedron_pick.sv
// top level of the ray pick against a convex solid held as a plane store
//
//   channel   ports                        handshake
//   request   start, busy, req_word        taken when start high and busy low
//   response  rsp_valid, rsp_word          one-cycle strobe, no back pressure
//
// a load writes the plane store and leaves busy low
// a query evaluates each plane, divides for each candidate plane and tests
// its hit point against the planes in turn, then forms squares and square
// root, all on the shared 34x34 multiplier and the one-bit-per-cycle divider
// and root units
// reset is synchronous and clears the sequencer and the result strobe
// the result and its strobe are registered from the done state
module ray_convex_hexahedron_pick
   import rchp_pkg::*;
#(
   parameter int PLANE_COUNT = 6,
   parameter int FRAC_BITS   = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_valid,
   output rsp_type rsp_word
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   rchp_ctrl #(
      .PLANE_COUNT(PLANE_COUNT)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .operation(req_word.operation),
      .status(status),
      .cmd(cmd),
      .busy(busy)
   );

   // arithmetic and storage
   rchp_datapath #(
      .PLANE_COUNT(PLANE_COUNT),
      .FRAC_BITS(FRAC_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .req_word(req_word),
      .cmd(cmd),
      .status(status),
      .rsp_word(rsp_word),
      .rsp_valid(rsp_valid)
   );

endmodule

>>> hw/rtl/rchp_ctrl.sv
// sequencer for plane loads and ray queries
module rchp_ctrl
   import rchp_pkg::*;
#(
   parameter int PLANE_COUNT = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          operation,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy
);

   localparam logic [PLANE_SEL_W-1:0] LAST_PLANE = PLANE_SEL_W'(PLANE_COUNT - 1);
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
   localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);

   state_type state_ff, state_in;
   logic [PLANE_SEL_W-1:0] plane_ff, plane_in;
   logic [PLANE_SEL_W-1:0] check_ff, check_in;
   logic [1:0] term_ff, term_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         plane_ff <= '0;
         check_ff <= '0;
         term_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         plane_ff <= plane_in;
         check_ff <= check_in;
         term_ff  <= term_in;
         step_ff  <= step_in;
      end
   end

   // next state and counters
   always_comb begin
      state_in = state_ff;
      plane_in = plane_ff;
      check_in = check_ff;
      term_in  = term_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && operation == OP_QUERY) begin
               state_in = S_PLANE;
               plane_in = '0;
            end
         end
         S_PLANE: begin
            state_in = S_VMUL;
            term_in  = '0;
         end
         S_VMUL: state_in = S_VACC;
         S_VACC: begin
            if (term_ff == 2'd2) begin
               state_in = S_VSAVE;
               term_in  = '0;
            end else begin
               state_in = S_VMUL;
               term_in  = term_ff + 2'd1;
            end
         end
         S_VSAVE: state_in = S_DMUL;
         S_DMUL:  state_in = S_DACC;
         S_DACC: begin
            if (term_ff == 2'd2) begin
               state_in = S_DSAVE;
               term_in  = '0;
            end else begin
               state_in = S_DMUL;
               term_in  = term_ff + 2'd1;
            end
         end
         S_DSAVE: state_in = S_CHECK;
         S_CHECK: begin
            step_in = '0;
            if (status.cand) begin
               state_in = S_DIV;
            end else if (plane_ff == LAST_PLANE) begin
               state_in = S_SQINIT;
            end else begin
               state_in = S_PLANE;
               plane_in = plane_ff + 1'b1;
            end
         end
         S_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = S_PMUL;
               term_in  = '0;
            end
         end
         S_PMUL: state_in = S_PSET;
         S_PSET: begin
            if (term_ff == 2'd2) begin
               state_in = S_IINIT;
               term_in  = '0;
               check_in = '0;
            end else begin
               state_in = S_PMUL;
               term_in  = term_ff + 2'd1;
            end
         end
         S_IINIT: begin
            state_in = S_IMUL;
            term_in  = '0;
         end
         S_IMUL: state_in = S_IACC;
         S_IACC: begin
            if (term_ff == 2'd2) begin
               state_in = S_ICHK;
               term_in  = '0;
            end else begin
               state_in = S_IMUL;
               term_in  = term_ff + 2'd1;
            end
         end
         S_ICHK: begin
            if (status.tol_fail) begin
               if (plane_ff == LAST_PLANE) begin
                  state_in = S_SQINIT;
               end else begin
                  state_in = S_PLANE;
                  plane_in = plane_ff + 1'b1;
               end
            end else if (check_ff == LAST_PLANE) begin
               state_in = S_UPDATE;
            end else begin
               state_in = S_IINIT;
               check_in = check_ff + 1'b1;
            end
         end
         S_UPDATE: begin
            if (plane_ff == LAST_PLANE) begin
               state_in = S_SQINIT;
            end else begin
               state_in = S_PLANE;
               plane_in = plane_ff + 1'b1;
            end
         end
         S_SQINIT: begin
            state_in = S_SQMUL;
            term_in  = '0;
         end
         S_SQMUL: state_in = S_SQACC;
         S_SQACC: begin
            if (term_ff == 2'd2) begin
               state_in = S_SQRTI;
               term_in  = '0;
            end else begin
               state_in = S_SQMUL;
               term_in  = term_ff + 2'd1;
            end
         end
         S_SQRTI: begin
            state_in = S_SQRT;
            step_in  = '0;
         end
         S_SQRT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == SQRT_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd.op    = DP_NONE;
      cmd.plane = plane_ff;
      cmd.term  = term_ff;
      busy      = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op = (operation == OP_QUERY) ? DP_CAPTURE : DP_LOAD;
            end
         end
         S_PLANE:  cmd.op = DP_VAL_INIT;
         S_VMUL:   cmd.op = DP_MUL_ORIGIN;
         S_VACC:   cmd.op = DP_ACC;
         S_VSAVE:  cmd.op = DP_SAVE_VAL;
         S_DMUL:   cmd.op = DP_MUL_DIR;
         S_DACC:   cmd.op = DP_ACC;
         S_DSAVE:  cmd.op = DP_SAVE_DOT;
         S_CHECK:  cmd.op = DP_DIV_INIT;
         S_DIV:    cmd.op = DP_DIV_STEP;
         S_PMUL:   cmd.op = DP_MUL_T;
         S_PSET:   cmd.op = DP_PT_SET;
         S_IINIT: begin
            cmd.op    = DP_IN_INIT;
            cmd.plane = check_ff;
         end
         S_IMUL: begin
            cmd.op    = DP_MUL_POINT;
            cmd.plane = check_ff;
         end
         S_IACC:   cmd.op = DP_ACC;
         S_ICHK:   cmd.op = DP_NONE;
         S_UPDATE: cmd.op = DP_UPDATE;
         S_SQINIT: cmd.op = DP_SQ_INIT;
         S_SQMUL:  cmd.op = DP_MUL_SQ;
         S_SQACC:  cmd.op = DP_SQ_ACC;
         S_SQRTI:  cmd.op = DP_SQRT_INIT;
         S_SQRT:   cmd.op = DP_SQRT_STEP;
         S_DONE:   cmd.op = DP_EMIT;
         default:  cmd.op = DP_NONE;
      endcase
   end

   // an accepted query keeps the block busy, a load does not
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && operation == OP_QUERY) |=> busy)
      else $error("query accepted but block not busy");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && operation == OP_LOAD) |=> !busy)
      else $error("load left block busy");
   a_plane_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> (plane_ff <= LAST_PLANE && check_ff <= LAST_PLANE))
      else $error("plane counter out of range");

endmodule

>>> hw/rtl/rchp_datapath.sv
// plane store, shared multiplier, divider, square root and result register
module rchp_datapath
   import rchp_pkg::*;
#(
   parameter int PLANE_COUNT = 6,
   parameter int FRAC_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_word,
   input  dp_cmd_type cmd,
   output dp_status_type status,
   output rsp_type    rsp_word,
   output logic       rsp_valid
);

   localparam int IDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
   localparam int ACC_W = 65 - FRAC_BITS;
   localparam int DIV_W = ACC_W + 31;
   localparam logic signed [ACC_W-1:0] TOL = ACC_W'(((1 << FRAC_BITS) + 500) / 1000);
   localparam logic signed [ACC_W-1:0] PT_MAX = ACC_W'(64'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] PT_MIN = -ACC_W'(64'sh8000_0000);

   // plane store
   logic signed [31:0] coef_a_ff [PLANE_COUNT];
   logic signed [31:0] coef_b_ff [PLANE_COUNT];
   logic signed [31:0] coef_c_ff [PLANE_COUNT];
   logic signed [31:0] coef_d_ff [PLANE_COUNT];

   logic [31:0] wr_ext;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;
   assign wr_ext = 32'(req_word.plane_index);
   assign wr_idx = wr_ext[IDX_W-1:0];
   assign rd_idx = cmd.plane[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.op == DP_LOAD && wr_ext < 32'(PLANE_COUNT)) begin
         coef_a_ff[wr_idx] <= req_word.coef_a;
         coef_b_ff[wr_idx] <= req_word.coef_b;
         coef_c_ff[wr_idx] <= req_word.coef_c;
         coef_d_ff[wr_idx] <= req_word.coef_d;
      end
   end

   logic signed [31:0] rd_coef;
   logic signed [31:0] rd_d;
   assign rd_d = coef_d_ff[rd_idx];
   always_comb begin
      unique case (cmd.term)
         2'd0:    rd_coef = coef_a_ff[rd_idx];
         2'd1:    rd_coef = coef_b_ff[rd_idx];
         default: rd_coef = coef_c_ff[rd_idx];
      endcase
   end

   // ray registers
   logic signed [31:0] org_ff [3];
   logic signed [31:0] dir_ff [3];
   logic signed [31:0] pt_ff [3];
   logic signed [31:0] best_ff [3];

   // working registers
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] val_ff;
   logic signed [ACC_W-1:0] dot_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] dvs_ff;
   logic [30:0] quo_ff;
   logic ovf_ff;
   logic found_ff;
   logic [30:0] best_t_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [63:0] rad_ff;
   logic [63:0] root_ff;
   logic [63:0] bit_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;

   // shared multiplier operands
   logic signed [31:0] org_t, dir_t, pt_t;
   logic [30:0] t_val;
   logic signed [32:0] diff;
   logic [32:0] diff_mag;
   logic signed [MUL_W-1:0] mul_a, mul_b;

   assign org_t = org_ff[cmd.term];
   assign dir_t = dir_ff[cmd.term];
   assign pt_t  = pt_ff[cmd.term];
   assign t_val = ovf_ff ? 31'h7FFF_FFFF : quo_ff;
   assign diff  = 33'(best_ff[cmd.term]) - 33'(org_t);
   assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

   always_comb begin
      unique case (cmd.op)
         DP_MUL_ORIGIN: begin
            mul_a = MUL_W'(rd_coef);
            mul_b = MUL_W'(org_t);
         end
         DP_MUL_DIR: begin
            mul_a = MUL_W'(rd_coef);
            mul_b = MUL_W'(dir_t);
         end
         DP_MUL_T: begin
            mul_a = MUL_W'(dir_t);
            mul_b = $signed({3'b000, t_val});
         end
         DP_MUL_POINT: begin
            mul_a = MUL_W'(rd_coef);
            mul_b = MUL_W'(pt_t);
         end
         default: begin
            mul_a = $signed({1'b0, diff_mag});
            mul_b = $signed({1'b0, diff_mag});
         end
      endcase
   end

   // floor-shifted product and point clamp
   logic signed [PROD_W-1:0] prod_sh;
   logic signed [ACC_W-1:0] prod_q;
   logic signed [ACC_W-1:0] pt_sum;
   logic signed [31:0] pt_clamp;
   assign prod_sh = prod_ff >>> FRAC_BITS;
   assign prod_q  = $signed(prod_sh[ACC_W-1:0]);
   assign pt_sum  = ACC_W'(org_t) + prod_q;
   always_comb begin
      priority if (pt_sum > PT_MAX) pt_clamp = 32'sh7FFF_FFFF;
      else if (pt_sum < PT_MIN)     pt_clamp = 32'sh8000_0000;
      else                          pt_clamp = pt_sum[31:0];
   end

   // magnitudes for the divider
   logic [ACC_W-1:0] val_mag, dot_mag;
   assign val_mag = val_ff[ACC_W-1] ? ACC_W'(-val_ff) : ACC_W'(val_ff);
   assign dot_mag = dot_ff[ACC_W-1] ? ACC_W'(-dot_ff) : ACC_W'(dot_ff);

   // square root trial
   logic [63:0] trial;
   assign trial = root_ff + bit_ff;

   logic better;
   assign better = !found_ff || (t_val < best_t_ff);

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         DP_CAPTURE: begin
            org_ff[0] <= req_word.origin_x;
            org_ff[1] <= req_word.origin_y;
            org_ff[2] <= req_word.origin_z;
            dir_ff[0] <= req_word.dir_x;
            dir_ff[1] <= req_word.dir_y;
            dir_ff[2] <= req_word.dir_z;
            best_ff[0] <= '0;
            best_ff[1] <= '0;
            best_ff[2] <= '0;
            best_t_ff  <= '0;
         end
         DP_VAL_INIT, DP_IN_INIT: acc_ff <= ACC_W'(rd_d);
         DP_MUL_ORIGIN, DP_MUL_DIR, DP_MUL_T, DP_MUL_POINT, DP_MUL_SQ:
            prod_ff <= mul_a * mul_b;
         DP_ACC: acc_ff <= acc_ff + prod_q;
         DP_SAVE_VAL: begin
            val_ff <= acc_ff;
            acc_ff <= '0;
         end
         DP_SAVE_DOT: dot_ff <= acc_ff;
         DP_DIV_INIT: begin
            rem_ff <= DIV_W'(val_mag) << FRAC_BITS;
            dvs_ff <= DIV_W'(dot_mag) << DIV_STEPS - 1;
            quo_ff <= '0;
            ovf_ff <= (DIV_W'(val_mag) >= (DIV_W'(dot_mag) << (31 - FRAC_BITS)));
         end
         DP_DIV_STEP: begin
            if (rem_ff >= dvs_ff) begin
               rem_ff <= rem_ff - dvs_ff;
               quo_ff <= {quo_ff[29:0], 1'b1};
            end else begin
               quo_ff <= {quo_ff[29:0], 1'b0};
            end
            dvs_ff <= dvs_ff >> 1;
         end
         DP_PT_SET: pt_ff[cmd.term] <= pt_clamp;
         DP_UPDATE: begin
            if (better) begin
               best_t_ff  <= t_val;
               best_ff[0] <= pt_ff[0];
               best_ff[1] <= pt_ff[1];
               best_ff[2] <= pt_ff[2];
            end
         end
         DP_SQ_INIT: sum_ff <= '0;
         DP_SQ_ACC:  sum_ff <= sum_ff + prod_ff[SUM_W-1:0];
         DP_SQRT_INIT: begin
            rad_ff  <= sum_ff[63:0];
            root_ff <= '0;
            bit_ff  <= 64'h4000_0000_0000_0000;
         end
         DP_SQRT_STEP: begin
            if (rad_ff >= trial) begin
               rad_ff  <= rad_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         DP_EMIT: begin
            rsp_ff.hit       <= found_ff;
            rsp_ff.hit_x     <= best_ff[0];
            rsp_ff.hit_y     <= best_ff[1];
            rsp_ff.hit_z     <= best_ff[2];
            rsp_ff.ray_param <= best_t_ff;
            if (!found_ff || sum_ff[SUM_W-1:64] != '0) begin
               rsp_ff.distance <= '1;
            end else begin
               rsp_ff.distance <= root_ff[31:0];
            end
         end
         default: begin
         end
      endcase
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.op == DP_EMIT);
         if (cmd.op == DP_CAPTURE) begin
            found_ff <= 1'b0;
         end else if (cmd.op == DP_UPDATE) begin
            found_ff <= 1'b1;
         end
      end
   end

   assign status.cand = (val_ff != '0) && (dot_ff != '0)
                        && (val_ff[ACC_W-1] != dot_ff[ACC_W-1]);
   assign status.tol_fail = (acc_ff > TOL);
   assign rsp_word  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   // a result is a single-cycle strobe
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held");
   a_miss_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.hit) |-> (rsp_word.distance == 32'hFFFF_FFFF
         && rsp_word.ray_param == '0))
      else $error("miss result not formatted");

endmodule
